// ----- rtl/core/sigmoid_f32_exp_poly_newton_macros.svh -----
// ----------------------------------------------------------------------------
// sigmoid_f32_exp_poly_newton_macros.svh
// Assertion macros shared by the sigmoid checker.
// ----------------------------------------------------------------------------
`ifndef SIGMOID_F32_EXP_POLY_NEWTON_MACROS_SVH
`define SIGMOID_F32_EXP_POLY_NEWTON_MACROS_SVH

// Same-cycle implication, muted while reset is high.
`define SGM_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sgm assertion failed");

// Next-cycle implication, also checked across reset.
`define SGM_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("sgm assertion failed");

`endif

// ----- rtl/core/sgm_pkg.sv -----
// ----------------------------------------------------------------------------
// sgm_pkg
// Types, constants and single-precision arithmetic for the sigmoid pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sgm_pkg;

  localparam int NSTAGE    = 35;
  localparam int SEED_BITS = 12;
  localparam int DROP      = 24 - SEED_BITS;

  localparam logic [31:0] MAGIC   = 32'h4B40007F;
  localparam logic [31:0] LOG2E   = 32'h3FB8AA3B;
  localparam logic [31:0] MLN2_HI = 32'hBF317200;
  localparam logic [31:0] MLN2_LO = 32'hB5BFBE8E;
  localparam logic [31:0] C5      = 32'h3C07CFCE;
  localparam logic [31:0] C4      = 32'h3D2B9D0D;
  localparam logic [31:0] C3      = 32'h3E2AAD40;
  localparam logic [31:0] C2      = 32'h3EFFFEE3;
  localparam logic [31:0] C1      = 32'h3F7FFFFB;
  localparam logic [31:0] ONE     = 32'h3F800000;
  localparam logic [31:0] TWO     = 32'h40000000;
  localparam logic [30:0] CUTOFF_MAG = 31'h42AEAC4F;
  localparam logic [30:0] INF_MAG    = 31'h7F800000;
  localparam logic [31:0] QNAN_SET   = 32'hFFC00000;
  localparam logic [30:0] SEED_HALF  = 31'(1 << (DROP - 1));
  localparam logic [30:0] SEED_KEEP  = ~31'((1 << DROP) - 1);

  // One item as it moves down the pipeline
  typedef struct packed {
    logic        last;
    logic        neg;
    logic        ovr;
    logic [31:0] ovr_val;
    logic [31:0] z;
    logic [31:0] a;
    logic [31:0] s;
    logic [31:0] n;
    logic [31:0] t;
    logic [31:0] p;
    logic [31:0] ts;
    logic [31:0] e;
    logic [31:0] d;
    logic [31:0] r;
    logic [23:0] dv;
    logic [24:0] rem;
    logic [24:0] q;
  } sgm_item_t;

  // Leading zero count of a 50-bit word (50 when zero)
  function automatic logic [5:0] lzc50(input logic [49:0] m);
    logic [5:0] n;
    n = 6'd50;
    for (int i = 0; i < 50; i++) begin
      if (m[i]) n = 6'(49 - i);
    end
    return n;
  endfunction

  // Normalize, round to nearest even and pack; value = m * 2^x
  function automatic logic [31:0] round_pack(input logic sgn, input logic signed [11:0] x,
                                             input logic [49:0] m);
    logic [5:0]         lz;
    logic [49:0]        mn;
    logic signed [11:0] e;
    logic [26:0]        m27;
    logic [26:0]        lost;
    logic [4:0]         sh;
    logic [23:0]        sig;
    logic               up;
    logic [30:0]        mag;
    lz  = lzc50(m);
    mn  = m << lz;
    e   = x + 12'sd176 - $signed({6'b0, lz});
    m27 = {mn[49:24], |mn[23:0]};
    // denormalize below the normal range
    if (e <= 12'sd0) begin
      if (e < -12'sd25) begin
        m27 = {26'b0, |m27};
      end else begin
        sh   = 5'(12'sd1 - e);
        lost = m27 & ((27'd1 << sh) - 27'd1);
        m27  = (m27 >> sh) | {26'b0, |lost};
      end
    end
    sig = m27[26:3];
    up  = m27[2] & ((|m27[1:0]) | sig[0]);
    if (e >= 12'sd255) begin
      mag = INF_MAG;
    end else begin
      mag = {((e > 12'sd0) ? e[7:0] : 8'd0), sig[22:0]} + {30'b0, up};
    end
    if (m == 50'd0) mag = 31'd0;
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [47:0]        p;
    logic signed [11:0] x;
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    ma = {a[30:23] != 8'd0, a[22:0]};
    mb = {b[30:23] != 8'd0, b[22:0]};
    p  = ma * mb;
    x  = $signed({4'b0, ea}) + $signed({4'b0, eb}) - 12'sd302;
    return round_pack(a[31] ^ b[31], x, {p, 2'b0});
  endfunction

  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] hi;
    logic [31:0] lo;
    logic [7:0]  e1;
    logic [7:0]  e2;
    logic [7:0]  dif;
    logic [27:0] bg;
    logic [27:0] sm;
    logic [27:0] lost;
    logic [27:0] sum;
    logic [31:0] res;
    if (b[30:0] > a[30:0]) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    e1  = (hi[30:23] == 8'd0) ? 8'd1 : hi[30:23];
    e2  = (lo[30:23] == 8'd0) ? 8'd1 : lo[30:23];
    dif = e1 - e2;
    bg  = {1'b0, hi[30:23] != 8'd0, hi[22:0], 3'b0};
    sm  = {1'b0, lo[30:23] != 8'd0, lo[22:0], 3'b0};
    // align the smaller operand, folding lost bits into a sticky bit
    if (dif >= 8'd28) begin
      sm = {27'b0, |sm};
    end else begin
      lost = sm & ((28'd1 << dif[4:0]) - 28'd1);
      sm   = (sm >> dif[4:0]) | {27'b0, |lost};
    end
    sum = (hi[31] == lo[31]) ? bg + sm : bg - sm;
    if (sum == 28'd0) begin
      res = {hi[31] & lo[31], 31'b0};
    end else begin
      res = round_pack(hi[31], $signed({4'b0, e1}) - 12'sd153, {22'b0, sum});
    end
    return res;
  endfunction

  function automatic logic [31:0] fsub(input logic [31:0] a, input logic [31:0] b);
    return fadd(a, {~b[31], b[30:0]});
  endfunction

  // Four restoring division steps of 2^48 / dv
  function automatic sgm_item_t div_step(input sgm_item_t i);
    sgm_item_t   o;
    logic [24:0] r2;
    o = i;
    for (int k = 0; k < 4; k++) begin
      r2 = {o.rem[23:0], 1'b0};
      if (r2 >= {1'b0, o.dv}) begin
        o.rem = r2 - {1'b0, o.dv};
        o.q   = {o.q[23:0], 1'b1};
      end else begin
        o.rem = r2;
        o.q   = {o.q[23:0], 1'b0};
      end
    end
    return o;
  endfunction

  // Rounded reciprocal of d, then cut to the seed precision
  function automatic logic [31:0] recip_seed(input sgm_item_t i);
    logic [7:0]  ed;
    logic        up;
    logic [24:0] mq;
    logic [31:0] rb;
    logic [30:0] mag;
    ed = i.d[30:23];
    up = i.q[0] & ((i.rem != 25'd0) | i.q[1]);
    mq = {1'b0, i.q[24:1]} + {24'b0, up};
    if (i.d[22:0] == 23'd0) begin
      rb = {1'b0, 8'd254 - ed, 23'b0};
    end else if (mq[24]) begin
      rb = {1'b0, 8'd254 - ed, 23'b0};
    end else begin
      rb = {1'b0, 8'd253 - ed, mq[22:0]};
    end
    mag = rb[30:0];
    if (mag != 31'd0 && mag[30:23] != 8'hFF) begin
      mag = (mag + SEED_HALF) & SEED_KEEP;
      if (mag > INF_MAG) mag = INF_MAG;
    end
    return {rb[31], mag};
  endfunction

  // Work done by pipeline stage k
  function automatic sgm_item_t stage_fn(input logic [5:0] k, input sgm_item_t i);
    sgm_item_t   o;
    logic [30:0] mag;
    logic        nan;
    o   = i;
    mag = i.z[30:0];
    nan = mag > INF_MAG;
    case (k)
      6'd0: begin
        o.neg     = i.z[31];
        o.ovr     = nan | (mag > CUTOFF_MAG);
        o.ovr_val = nan ? (i.z | QNAN_SET) : (i.z[31] ? 32'd0 : ONE);
        o.z       = i.z | 32'h80000000;
      end
      6'd1:  o.a = fmul(i.z, LOG2E);
      6'd2:  o.a = fadd(i.a, MAGIC);
      6'd3: begin
        o.s = {i.a[8:0], 23'b0};
        o.n = fsub(i.a, MAGIC);
      end
      6'd4:  o.a = fmul(i.n, MLN2_HI);
      6'd5:  o.t = fadd(i.a, i.z);
      6'd6:  o.a = fmul(i.n, MLN2_LO);
      6'd7:  o.t = fadd(i.a, i.t);
      6'd8: begin
        o.p  = fmul(C5, i.t);
        o.ts = fmul(i.t, i.s);
      end
      6'd9:  o.p = fadd(i.p, C4);
      6'd10: o.p = fmul(i.p, i.t);
      6'd11: o.p = fadd(i.p, C3);
      6'd12: o.p = fmul(i.p, i.t);
      6'd13: o.p = fadd(i.p, C2);
      6'd14: o.p = fmul(i.p, i.t);
      6'd15: o.p = fadd(i.p, C1);
      6'd16: o.a = fmul(i.ts, i.p);
      6'd17: o.e = fadd(i.a, i.s);
      6'd18: o.d = fadd(i.e, ONE);
      6'd19: begin
        o.dv  = {1'b1, i.d[22:0]};
        o.rem = 25'h1000000 - {1'b0, 1'b1, i.d[22:0]};
        o.q   = 25'd1;
      end
      6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25: o = div_step(i);
      6'd26: o.r = recip_seed(i);
      6'd27: o.a = fmul(i.r, i.d);
      6'd28: o.a = fsub(TWO, i.a);
      6'd29: o.r = fmul(i.r, i.a);
      6'd30: o.a = fmul(i.r, i.d);
      6'd31: o.a = fsub(TWO, i.a);
      6'd32: o.r = fmul(i.r, i.a);
      6'd33: o.a = fmul(i.e, i.r);
      6'd34: o.a = i.ovr ? i.ovr_val : (i.neg ? i.a : fsub(ONE, i.a));
      default: o = i;
    endcase
    return o;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/sgm_flow.sv -----
// ----------------------------------------------------------------------------
// sgm_flow
// Per-stage load enables: a stage moves when it or any later stage holds a bubble
// or the output side is not stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sgm_flow
  import sgm_pkg::*;
(
  input  wire logic [NSTAGE-1:0] vld,
  input  wire logic              out_stall,
  output logic      [NSTAGE-1:0] ce
);

  localparam logic [NSTAGE-1:0] ONES = '1;

  // bubble at or after stage k lets stage k load
  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      ce[k] = ~out_stall | (|(~vld & (ONES << k)));
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/sigmoid_f32_exp_poly_newton.sv -----
// Throughput: one item per cycle while no output stall backs up a full pipeline;
// most stages do one single-precision operation or four reciprocal quotient bits.
// Stalls collapse bubbles; the input stalls only when all 35 stages are full.
// Reset clears every stage valid bit; data registers are not reset.
// ----------------------------------------------------------------------------
// sigmoid_f32_exp_poly_newton
// Streaming single-precision sigmoid, exp polynomial and Newton reciprocal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sigmoid_f32_exp_poly_newton
  import sgm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [31:0] x_bits,
  input  wire logic        last_in,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      y_bits,
  output logic             last_out
);

  sgm_item_t         in_item;
  sgm_item_t         pipe [NSTAGE];
  logic              vld  [NSTAGE];
  logic [NSTAGE-1:0] vld_vec;
  logic [NSTAGE-1:0] ce;

  // raw input enters through the z field
  always_comb begin
    in_item      = '0;
    in_item.z    = x_bits;
    in_item.last = last_in;
  end

  always_comb begin
    for (int k = 0; k < NSTAGE; k++) begin
      vld_vec[k] = vld[k];
    end
  end

  sgm_flow u_flow (
    .vld       (vld_vec),
    .out_stall (out_stall),
    .ce        (ce)
  );

  // stage registers
  for (genvar g = 0; g < NSTAGE; g++) begin : g_stage
    sgm_item_t src;
    logic      src_vld;
    if (g == 0) begin : g_first
      assign src     = in_item;
      assign src_vld = in_valid;
    end else begin : g_rest
      assign src     = pipe[g-1];
      assign src_vld = vld[g-1];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[g] <= 1'b0;
      end else if (ce[g]) begin
        vld[g] <= src_vld;
      end
    end

    always_ff @(posedge clk) begin
      if (ce[g]) begin
        pipe[g] <= stage_fn(6'(g), src);
      end
    end
  end

  assign in_stall  = ~ce[0];
  assign out_valid = vld[NSTAGE-1];
  assign y_bits    = pipe[NSTAGE-1].a;
  assign last_out  = pipe[NSTAGE-1].last;

endmodule

`default_nettype wire

// ----- rtl/core/sgm_chk.sv -----
// ----------------------------------------------------------------------------
// sgm_chk
// Port-level checks on the sigmoid pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sigmoid_f32_exp_poly_newton_macros.svh"

module sgm_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [31:0] y_bits,
  input wire logic        last_out
);

  // a stalled result holds
  `SGM_ASSERT_NXT(a_hold, !rst && out_valid && out_stall, rst || (out_valid && $stable({y_bits, last_out})))

  // input backs up only when the pipe is full and the output is stalled
  `SGM_ASSERT_IMP(a_full, in_stall, out_valid && out_stall)

  // reset empties the pipe
  `SGM_ASSERT_NXT(a_rst, rst, !out_valid)

endmodule

bind sigmoid_f32_exp_poly_newton sgm_chk u_chk (.*);

`default_nettype wire

// ----- bench/sigmoid_f32_exp_poly_newton_test.sv -----
// ----------------------------------------------------------------------------
// sigmoid_f32_exp_poly_newton_test
// Streams single-precision values through the sigmoid pipeline with random
// gaps and output stalls. Each output is compared bit for bit with a local
// soft-float model, and last_out is checked against last_in.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sigmoid_f32_exp_poly_newton_test;

  localparam int          SEED_BITS  = 12;
  localparam int          NUM_RAND   = 1600;
  localparam int          IDLE_LIMIT = 5000;
  localparam logic [31:0] K_MAGIC    = 32'h4B40007F;
  localparam logic [31:0] K_LOG2E    = 32'h3FB8AA3B;
  localparam logic [31:0] K_LN2_HI   = 32'hBF317200;
  localparam logic [31:0] K_LN2_LO   = 32'hB5BFBE8E;
  localparam logic [31:0] K_C5       = 32'h3C07CFCE;
  localparam logic [31:0] K_C4       = 32'h3D2B9D0D;
  localparam logic [31:0] K_C3       = 32'h3E2AAD40;
  localparam logic [31:0] K_C2       = 32'h3EFFFEE3;
  localparam logic [31:0] K_C1       = 32'h3F7FFFFB;
  localparam logic [31:0] K_ONE      = 32'h3F800000;
  localparam logic [31:0] K_TWO      = 32'h40000000;
  localparam logic [30:0] K_CUTOFF   = 31'h42AEAC4F;
  localparam logic [30:0] K_INF      = 31'h7F800000;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] x_bits;
  logic        last_in;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] y_bits;
  logic        last_out;

  sigmoid_f32_exp_poly_newton i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .x_bits(x_bits), .last_in(last_in),
    .out_valid(out_valid), .out_stall(out_stall), .y_bits(y_bits), .last_out(last_out)
  );

  // Round m * 2^ex to single precision, nearest even
  function automatic logic [31:0] round_f32(input logic sgn, input int ex,
                                            input logic [127:0] m);
    int           msb;
    int           sh;
    int           be;
    logic [127:0] q;
    logic [127:0] rem;
    logic [127:0] half;
    longint       mg;
    if (m == 0) return {sgn, 31'd0};
    msb = 0;
    for (int i = 0; i < 128; i++) if (m[i]) msb = i;
    sh = msb - 23;
    be = msb + ex + 127;
    // subnormal: fewer significant bits kept
    if (be < 1) begin
      sh = sh + 1 - be;
      be = 1;
    end
    if (sh <= 0) begin
      q = m << (-sh);
    end else if (sh >= 127) begin
      q = 0;
    end else begin
      q    = m >> sh;
      rem  = m - (q << sh);
      half = 128'd1 << (sh - 1);
      if (rem > half || (rem == half && q[0])) q = q + 1;
    end
    mg = longint'(be - 1) * 64'd8388608 + longint'(q[40:0]);
    if (mg >= 64'h7F800000) mg = 64'h7F800000;
    return {sgn, mg[30:0]};
  endfunction

  // Significand and exponent of a finite value: a = m * 2^ex
  function automatic void split_f32(input logic [31:0] a, output logic [23:0] m,
                                    output int ex);
    if (a[30:23] == 8'd0) begin
      m  = {1'b0, a[22:0]};
      ex = -149;
    end else begin
      m  = {1'b1, a[22:0]};
      ex = int'(a[30:23]) - 150;
    end
  endfunction

  function automatic logic [31:0] mul_f32(input logic [31:0] a, input logic [31:0] b);
    logic [23:0] ma;
    logic [23:0] mb;
    int          ea;
    int          eb;
    if (a[30:0] == 0 || b[30:0] == 0) return {a[31] ^ b[31], 31'd0};
    split_f32(a, ma, ea);
    split_f32(b, mb, eb);
    return round_f32(a[31] ^ b[31], ea + eb, 128'(ma) * 128'(mb));
  endfunction

  function automatic logic [31:0] add_f32(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]  hi;
    logic [31:0]  lo;
    logic [23:0]  mh;
    logic [23:0]  ml;
    int           eh;
    int           el;
    int           ex;
    logic [127:0] big;
    logic [127:0] sml;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:0] == 0) return b;
    if (b[30:0] == 0) return a;
    if (b[30:23] > a[30:23]) begin
      hi = b;
      lo = a;
    end else begin
      hi = a;
      lo = b;
    end
    split_f32(hi, mh, eh);
    split_f32(lo, ml, el);
    // far apart: the small operand only acts as a sticky bit
    if (eh - el > 36) begin
      big = 128'(mh) << 38;
      sml = 128'd1;
      ex  = eh - 38;
    end else begin
      big = 128'(mh) << (eh - el);
      sml = 128'(ml);
      ex  = el;
    end
    if (hi[31] == lo[31]) return round_f32(hi[31], ex, big + sml);
    if (big == sml) return 32'd0;
    if (big > sml) return round_f32(hi[31], ex, big - sml);
    return round_f32(lo[31], ex, sml - big);
  endfunction

  function automatic logic [31:0] sub_f32(input logic [31:0] a, input logic [31:0] b);
    return add_f32(a, {~b[31], b[30:0]});
  endfunction

  // Correctly rounded 1/d cut to the seed precision (d is positive here)
  function automatic logic [31:0] seed_recip(input logic [31:0] d);
    logic [23:0]  md;
    int           ed;
    logic [127:0] q;
    logic [127:0] rem;
    logic [31:0]  r;
    logic [30:0]  mag;
    split_f32(d, md, ed);
    q   = (128'd1 << 90) / 128'(md);
    rem = (128'd1 << 90) - q * 128'(md);
    r   = round_f32(1'b0, -ed - 91, (q << 1) | 128'(rem != 0));
    mag = r[30:0];
    if (mag != 0 && mag[30:23] != 8'hFF) begin
      mag = (mag + 31'(1 << (23 - SEED_BITS))) & ~31'((1 << (24 - SEED_BITS)) - 1);
      if (mag > K_INF) mag = K_INF;
    end
    return {r[31], mag};
  endfunction

  function automatic logic [31:0] sigmoid_f32(input logic [31:0] x);
    logic [31:0] z;
    logic [31:0] nb;
    logic [31:0] s;
    logic [31:0] n;
    logic [31:0] t;
    logic [31:0] p;
    logic [31:0] ts;
    logic [31:0] e;
    logic [31:0] d;
    logic [31:0] r;
    logic [31:0] f;
    // NaN passes through quieted with the sign set
    if (x[30:0] > K_INF) return x | 32'hFFC00000;
    // beyond the cutoff the exp term is flushed to zero
    if (x[30:0] > K_CUTOFF) return x[31] ? 32'd0 : K_ONE;
    z  = {1'b1, x[30:0]};
    nb = add_f32(mul_f32(z, K_LOG2E), K_MAGIC);
    s  = {nb[8:0], 23'd0};
    n  = sub_f32(nb, K_MAGIC);
    t  = add_f32(mul_f32(n, K_LN2_HI), z);
    t  = add_f32(mul_f32(n, K_LN2_LO), t);
    p  = add_f32(mul_f32(K_C5, t), K_C4);
    p  = add_f32(mul_f32(p, t), K_C3);
    p  = add_f32(mul_f32(p, t), K_C2);
    p  = add_f32(mul_f32(p, t), K_C1);
    ts = mul_f32(t, s);
    e  = add_f32(mul_f32(ts, p), s);
    d  = add_f32(e, K_ONE);
    r  = seed_recip(d);
    r  = mul_f32(r, sub_f32(K_TWO, mul_f32(r, d)));
    r  = mul_f32(r, sub_f32(K_TWO, mul_f32(r, d)));
    f  = mul_f32(e, r);
    return x[31] ? f : sub_f32(K_ONE, f);
  endfunction

  // Expected outputs, oldest first
  class sigmoid_scoreboard;
    logic [32:0] pending_y[$];
    int          errors;
    int          checked;

    function void note_input(logic [31:0] x, logic last);
      pending_y.push_back({last, sigmoid_f32(x)});
    endfunction

    function void check_output(logic [31:0] y, logic last);
      logic [32:0] exp_y;
      if (pending_y.size() == 0) begin
        $error("unexpected output y_bits=%h last_out=%b", y, last);
        errors++;
        return;
      end
      exp_y = pending_y.pop_front();
      checked++;
      if (y !== exp_y[31:0]) begin
        $error("y_bits expected %h actual %h", exp_y[31:0], y);
        errors++;
      end
      if (last !== exp_y[32]) begin
        $error("last_out expected %b actual %b", exp_y[32], last);
        errors++;
      end
    endfunction
  endclass

  sigmoid_scoreboard sb;
  int  idle_cycles;
  int  stall_left;
  bit  calm;
  int  num_sent;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Random gap: mostly none or short, sometimes long; none in calm stretches
  function automatic int pick_gap();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // Output stall and result checking
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else begin
      if (out_valid && !out_stall) sb.check_output(y_bits, last_out);
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall  <= 1'b1;
      end else begin
        stall_left <= pick_gap();
        out_stall  <= 1'b0;
      end
    end
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  task automatic send_item(input logic [31:0] x, input logic last);
    int gap;
    in_valid <= 1'b1;
    x_bits   <= x;
    last_in  <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_input(x, last);
    num_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Random value: moderate range half of the time, plus small values, edges and raw bits
  function automatic logic [31:0] rand_x();
    logic [31:0] v;
    int          kind;
    v    = $urandom;
    kind = $urandom_range(0, 9);
    if (kind < 5) begin
      v[30:23] = 8'($urandom_range(100, 133));
    end else if (kind == 5) begin
      v[30:0] = K_CUTOFF + 31'($urandom_range(0, 16)) - 31'd8;
    end else if (kind == 6) begin
      v[30:23] = 8'($urandom_range(0, 1) ? 8'hFF : 8'h00);
    end else if (kind == 7) begin
      v[30:23] = 8'($urandom_range(60, 99));
    end
    return v;
  endfunction

  logic [31:0] directed_x[$] = '{
    32'h00000000, 32'h80000000, 32'h3F800000, 32'hBF800000, 32'h7F800000,
    32'hFF800000, 32'h7FC00000, 32'hFFC00000, 32'h7F800001, 32'hFF800001,
    32'h7FFFFFFF, 32'h42AEAC4F, 32'hC2AEAC4F, 32'h42AEAC50, 32'hC2AEAC50,
    32'h42AEAC4E, 32'h00000001, 32'h807FFFFF, 32'h7F7FFFFF, 32'hFF7FFFFF,
    32'h33800000, 32'h3F000000, 32'hC1200000, 32'h41200000
  };

  initial begin
    sb          = new();
    rst         = 1'b1;
    in_valid    = 1'b0;
    x_bits      = 32'd0;
    last_in     = 1'b0;
    out_stall   = 1'b0;
    stall_left  = 0;
    idle_cycles = 0;
    calm        = 1'b0;
    num_sent    = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Extremes, signed zeros, infinities, NaNs and the cutoff boundary
    foreach (directed_x[i]) send_item(directed_x[i], 1'(i % 2));

    for (int i = 0; i < NUM_RAND; i++) begin
      if (i % 200 == 0) calm = ($urandom_range(0, 2) == 0);
      // sender holds off until the pipeline has drained
      if (i == NUM_RAND / 2) begin
        in_valid <= 1'b0;
        while (sb.pending_y.size() != 0) @(posedge clk);
      end
      send_item(rand_x(), 1'($urandom_range(0, 7) == 0));
    end
    in_valid <= 1'b0;
    calm     = 1'b1;

    while (sb.pending_y.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("Sent %0d values (directed edges plus random), checked %0d outputs,",
             num_sent, sb.checked);
    $display("with random input gaps and output stalls and one full drain.");
    if (sb.errors == 0 && sb.pending_y.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
